[design/dsu_pkg.sv]
// Shared types and constants for the union-find by size block.
// No dependencies; compiled first.
`default_nettype none

package dsu_pkg;

  localparam int unsigned NODE_COUNT_DEF = 1024;
  localparam int unsigned NODE_W         = 10;
  localparam int unsigned SIZE_W         = 11;

  typedef struct packed {
    logic              mode;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } req_t;

  typedef struct packed {
    logic [NODE_W-1:0] root_a;
    logic [NODE_W-1:0] root_b;
    logic              joined;
    logic              same_set;
    logic [SIZE_W-1:0] merged_size;
  } rsp_t;

  localparam logic MODE_UNION = 1'b0;
  localparam logic MODE_FIND  = 1'b1;

endpackage

`default_nettype wire

[design/dsu_if.sv]
// Valid/ready channels for requests and responses of the union-find block.
// Depends on dsu_pkg for the payload types.
`default_nettype none

interface dsu_req_if
  import dsu_pkg::*;
;
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface dsu_rsp_if
  import dsu_pkg::*;
;
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[design/dsu_ram.sv]
// Single-port-write, single-port-read RAM with registered read data.
// No package dependency.
`default_nettype none

module dsu_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 10,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/dsu_mod_reduce.sv]
// Reduces both node indices of a request modulo the node count.
// Reciprocal multiplication when needed, otherwise a registered mask. Uses dsu_pkg.
`default_nettype none

module dsu_mod_reduce
  import dsu_pkg::*;
#(
  parameter int unsigned NODE_COUNT = NODE_COUNT_DEF,
  parameter int unsigned IW         = $clog2(NODE_COUNT)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [NODE_W-1:0] node_a_i,
  input  wire logic [NODE_W-1:0] node_b_i,
  output logic                   done_o,
  output logic      [IW-1:0]     idx_a_o,
  output logic      [IW-1:0]     idx_b_o
);

  localparam bit NEED_MOD = (NODE_COUNT < (1 << NODE_W)) &&
                            ((NODE_COUNT & (NODE_COUNT - 1)) != 0);

  if (NEED_MOD) begin : g_recip
    // quotient = (x * RECIP) >> SH, exact for every NODE_W-bit x
    localparam int unsigned SH = NODE_W + $clog2(NODE_COUNT);
    localparam int unsigned MW = NODE_W + 2;
    localparam int unsigned PW = NODE_W + MW;
    localparam int unsigned QW = PW - SH;
    localparam logic [MW-1:0]     RECIP = MW'(((1 << SH) + NODE_COUNT - 1) / NODE_COUNT);
    localparam logic [NODE_W-1:0] NC    = NODE_W'(NODE_COUNT);

    logic [PW-1:0]     prod_a, prod_b;
    logic [NODE_W-1:0] qn_a, qn_b;
    logic [NODE_W-1:0] x_a_q, x_b_q, rem_a_q, rem_b_q;
    logic [QW-1:0]     quo_a_q, quo_b_q;
    logic              step_q, done_q;

    assign prod_a = {{MW{1'b0}}, node_a_i} * {{NODE_W{1'b0}}, RECIP};
    assign prod_b = {{MW{1'b0}}, node_b_i} * {{NODE_W{1'b0}}, RECIP};
    assign qn_a   = NODE_W'({{NODE_W{1'b0}}, quo_a_q} * {{QW{1'b0}}, NC});
    assign qn_b   = NODE_W'({{NODE_W{1'b0}}, quo_b_q} * {{QW{1'b0}}, NC});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        step_q <= 1'b0;
        done_q <= 1'b0;
      end else begin
        step_q <= start_i;
        done_q <= step_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        x_a_q   <= node_a_i;
        x_b_q   <= node_b_i;
        quo_a_q <= prod_a[PW-1:SH];
        quo_b_q <= prod_b[PW-1:SH];
      end
      if (step_q) begin
        rem_a_q <= x_a_q - qn_a;
        rem_b_q <= x_b_q - qn_b;
      end
    end

    assign done_o  = done_q;
    assign idx_a_o = IW'(rem_a_q);
    assign idx_b_o = IW'(rem_b_q);
  end else begin : g_mask
    logic [IW-1:0] idx_a_q, idx_b_q;
    logic          done_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        idx_a_q <= IW'(node_a_i);
        idx_b_q <= IW'(node_b_i);
      end
    end

    assign done_o  = done_q;
    assign idx_a_o = idx_a_q;
    assign idx_b_o = idx_b_q;
  end

endmodule

`default_nettype wire

[design/disjoint_set_union_by_size_unit.sv]
// Union-find by size: requests name two nodes and a mode (union or find); each request
// returns one response with both roots, whether they matched, whether a merge happened and
// the surviving set's size (node a's set when nothing merged). After reset the block runs a
// clearing pass over all NODE_COUNT nodes that makes every node its own root of size one;
// requests are refused until it ends. Requests are handled one at a time. A request first
// has its indices captured (with the reciprocal reduction when NODE_COUNT is below 1024 and
// not a power of two), then each node's root walk runs in two-link steps, then the size
// lookup and update follow, and the block returns to idle before it takes the next request.
// The walk is bound by the single read port of the parent memory. A finished response
// waits in an output register while the next request is taken.
// Uses dsu_pkg, dsu_if, dsu_ram and dsu_mod_reduce.
`default_nettype none

module disjoint_set_union_by_size_unit
  import dsu_pkg::*;
#(
  parameter int unsigned NODE_COUNT = NODE_COUNT_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dsu_req_if.sink    req_i,
  dsu_rsp_if.source  rsp_o
);

  localparam int unsigned IW = $clog2(NODE_COUNT);
  localparam int unsigned SW = $clog2(NODE_COUNT + 1);

  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_RED   = 4'd2;
  localparam logic [3:0] ST_ISSUE = 4'd3;
  localparam logic [3:0] ST_CHK   = 4'd4;
  localparam logic [3:0] ST_GRAND = 4'd5;
  localparam logic [3:0] ST_SZA   = 4'd6;
  localparam logic [3:0] ST_SZB   = 4'd7;
  localparam logic [3:0] ST_CALC  = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [IW-1:0]     init_cnt_q;
  logic              side_q;
  logic              mode_q;
  logic [IW-1:0]     cur_q, idx_b_q, ra_q, rb_q;
  logic [SW-1:0]     sa_q;
  rsp_t              rsp_q;
  logic              rsp_valid_q;

  logic              accept;
  logic              red_done;
  logic [IW-1:0]     red_idx_a, red_idx_b;
  logic [IW-1:0]     par_rdata, par_raddr, par_waddr, par_wdata;
  logic              par_we;
  logic [SW-1:0]     sz_rdata, sz_wdata;
  logic [IW-1:0]     sz_raddr, sz_waddr;
  logic              sz_we;
  logic              out_free, same, do_union, a_wins, finish;
  logic [SW-1:0]     sum;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !rsp_valid_q || rsp_o.ready;

  dsu_mod_reduce #(.NODE_COUNT(NODE_COUNT), .IW(IW)) u_reduce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .node_a_i (req_i.payload.node_a),
    .node_b_i (req_i.payload.node_b),
    .done_o   (red_done),
    .idx_a_o  (red_idx_a),
    .idx_b_o  (red_idx_b)
  );

  assign same     = (ra_q == rb_q);
  assign do_union = (mode_q == MODE_UNION) && !same;
  assign a_wins   = (sa_q >= sz_rdata);
  assign sum      = sa_q + sz_rdata;
  assign finish   = (state_q == ST_CALC) && out_free;

  always_comb begin
    par_raddr = cur_q;
    case (state_q) inside
      ST_CHK, ST_GRAND: par_raddr = par_rdata;
      default:          par_raddr = cur_q;
    endcase
  end

  always_comb begin
    if (state_q == ST_INIT) begin
      par_we    = 1'b1;
      par_waddr = init_cnt_q;
      par_wdata = init_cnt_q;
      sz_we     = 1'b1;
      sz_waddr  = init_cnt_q;
      sz_wdata  = SW'(1);
    end else begin
      par_we    = finish && do_union;
      par_waddr = a_wins ? rb_q : ra_q;
      par_wdata = a_wins ? ra_q : rb_q;
      sz_we     = finish && do_union;
      sz_waddr  = a_wins ? ra_q : rb_q;
      sz_wdata  = sum;
    end
  end

  assign sz_raddr = (state_q == ST_SZA) ? ra_q : rb_q;

  dsu_ram #(.DEPTH(NODE_COUNT), .WIDTH(IW), .AW(IW)) u_parent (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (par_waddr),
    .wdata_i (par_wdata),
    .raddr_i (par_raddr),
    .rdata_o (par_rdata)
  );

  dsu_ram #(.DEPTH(NODE_COUNT), .WIDTH(SW), .AW(IW)) u_size (
    .clk_i   (clk_i),
    .we_i    (sz_we),
    .waddr_i (sz_waddr),
    .wdata_i (sz_wdata),
    .raddr_i (sz_raddr),
    .rdata_o (sz_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT:  if (init_cnt_q == IW'(NODE_COUNT - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = ST_RED;
      ST_RED:   if (red_done) state_d = ST_ISSUE;
      ST_ISSUE: state_d = ST_CHK;
      ST_CHK: begin
        if (par_rdata != cur_q) begin
          state_d = ST_GRAND;
        end else if (!side_q) begin
          state_d = ST_ISSUE;
        end else begin
          state_d = ST_SZA;
        end
      end
      ST_GRAND: state_d = ST_CHK;
      ST_SZA:   state_d = ST_SZB;
      ST_SZB:   state_d = ST_CALC;
      ST_CALC:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_cnt_q  <= '0;
      side_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_INIT) begin
        init_cnt_q <= init_cnt_q + 1'b1;
      end
      if (state_q == ST_RED) begin
        side_q <= 1'b0;
      end else if (state_q == ST_CHK && par_rdata == cur_q) begin
        side_q <= 1'b1;
      end
      if (finish) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= req_i.payload.mode;
    end
    if (state_q == ST_RED && red_done) begin
      cur_q   <= red_idx_a;
      idx_b_q <= red_idx_b;
    end else if (state_q == ST_GRAND) begin
      cur_q <= par_rdata;
    end else if (state_q == ST_CHK && par_rdata == cur_q) begin
      if (!side_q) begin
        ra_q  <= cur_q;
        cur_q <= idx_b_q;
      end else begin
        rb_q <= cur_q;
      end
    end
    if (state_q == ST_SZB) begin
      sa_q <= sz_rdata;
    end
    if (finish) begin
      rsp_q.root_a      <= NODE_W'(ra_q);
      rsp_q.root_b      <= NODE_W'(rb_q);
      rsp_q.joined      <= do_union;
      rsp_q.same_set    <= same;
      rsp_q.merged_size <= SIZE_W'(do_union ? sum : sa_q);
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

endmodule

`default_nettype wire

[design/dsu_checker.sv]
// Port-level checks for the union-find block, bound to the top level.
// Uses dsu_pkg for payload widths.
`default_nettype none

module dsu_checker
  import dsu_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              req_valid_i,
  input wire logic              req_ready_i,
  input wire logic              rsp_valid_i,
  input wire logic              rsp_ready_i,
  input wire logic [NODE_W-1:0] root_a_i,
  input wire logic [NODE_W-1:0] root_b_i,
  input wire logic              joined_i,
  input wire logic              same_set_i,
  input wire logic [SIZE_W-1:0] merged_size_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(root_a_i) &&
      $stable(root_b_i) && $stable(merged_size_i) && $stable(joined_i))
    else $error("stalled response changed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in flight");

  a_same_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (same_set_i == (root_a_i == root_b_i)) && !(joined_i && same_set_i))
    else $error("same_set or joined inconsistent with roots");

  a_size_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> merged_size_i != '0 && (!joined_i || merged_size_i > SIZE_W'(1)))
    else $error("merged size out of range");

endmodule

bind disjoint_set_union_by_size_unit dsu_checker u_dsu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .root_a_i      (rsp_o.payload.root_a),
  .root_b_i      (rsp_o.payload.root_b),
  .joined_i      (rsp_o.payload.joined),
  .same_set_i    (rsp_o.payload.same_set),
  .merged_size_i (rsp_o.payload.merged_size)
);

`default_nettype wire
